// File: sv/nhcm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Nearest highlight colour match: shared package
// Widths, the fixed sixteen-entry highlight palette and the small helper
// functions used by the distance and minimum-search stages.
// ----------------------------------------------------------------------------
package nhcm_pkg;

  // Field widths.
  localparam int COLOR_W  = 24;
  localparam int INDEX_W  = 5;
  localparam int PAL_SIZE = 16;
  localparam int IDX_W    = $clog2(PAL_SIZE);
  // Largest distance is 3 * 255 = 765, which fits in ten bits.
  localparam int DIST_W   = 10;

  // Channel levels that make up the palette.
  localparam logic [7:0] LVL_NONE   = 8'h00;
  localparam logic [7:0] LVL_FULL   = 8'hFF;
  localparam logic [7:0] LVL_HALF   = 8'h80;
  localparam logic [7:0] LVL_SILVER = 8'hC0;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } rgb_t;

  // One contender in the minimum search: its distance and palette position.
  typedef struct packed {
    logic [DIST_W-1:0] score;
    logic [IDX_W-1:0]  idx;
  } cand_t;

  // Palette entry at zero-based position idx.
  function automatic rgb_t pal_entry(input logic [IDX_W-1:0] idx);
    rgb_t e;
    unique case (idx)
      4'd0:    e = '{LVL_NONE,   LVL_NONE,   LVL_NONE};
      4'd1:    e = '{LVL_NONE,   LVL_NONE,   LVL_FULL};
      4'd2:    e = '{LVL_NONE,   LVL_FULL,   LVL_FULL};
      4'd3:    e = '{LVL_NONE,   LVL_FULL,   LVL_NONE};
      4'd4:    e = '{LVL_FULL,   LVL_NONE,   LVL_FULL};
      4'd5:    e = '{LVL_FULL,   LVL_NONE,   LVL_NONE};
      4'd6:    e = '{LVL_FULL,   LVL_FULL,   LVL_NONE};
      4'd7:    e = '{LVL_FULL,   LVL_FULL,   LVL_FULL};
      4'd8:    e = '{LVL_NONE,   LVL_NONE,   LVL_HALF};
      4'd9:    e = '{LVL_NONE,   LVL_HALF,   LVL_HALF};
      4'd10:   e = '{LVL_NONE,   LVL_HALF,   LVL_NONE};
      4'd11:   e = '{LVL_HALF,   LVL_NONE,   LVL_HALF};
      4'd12:   e = '{LVL_HALF,   LVL_NONE,   LVL_NONE};
      4'd13:   e = '{LVL_HALF,   LVL_HALF,   LVL_NONE};
      4'd14:   e = '{LVL_HALF,   LVL_HALF,   LVL_HALF};
      default: e = '{LVL_SILVER, LVL_SILVER, LVL_SILVER};
    endcase
    return e;
  endfunction

  // Absolute difference of two channel bytes.
  function automatic logic [7:0] abs_diff(input logic [7:0] a, input logic [7:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

  // Keep the left contender unless the right one is strictly closer; the
  // left side always carries the lower palette positions, so ties go low.
  function automatic cand_t pick_best(input cand_t lo, input cand_t hi);
    return (hi.score < lo.score) ? hi : lo;
  endfunction

endpackage

// File: sv/nhcm_color_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Colour channel
// Valid/ready channel that carries one packed RGB colour per item.
// ----------------------------------------------------------------------------
interface nhcm_color_if
  import nhcm_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [COLOR_W-1:0] color_rgb;

  modport source (output valid, output color_rgb, input ready);
  modport sink   (input valid, input color_rgb, output ready);
endinterface

// File: sv/nhcm_index_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Highlight index channel
// Valid/ready channel that carries one 1-based palette index per item.
// ----------------------------------------------------------------------------
interface nhcm_index_if
  import nhcm_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [INDEX_W-1:0] highlight_index;

  modport source (output valid, output highlight_index, input ready);
  modport sink   (input valid, input highlight_index, output ready);
endinterface

// File: sv/nhcm_dist.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Palette distance lanes
// Sixteen parallel lanes, each giving the Manhattan distance from the input
// colour to one palette entry.
// ----------------------------------------------------------------------------
module nhcm_dist
  import nhcm_pkg::*;
(
  input  rgb_t                      color,
  output cand_t [PAL_SIZE-1:0]      cands
);

  // One lane per palette entry: sum of the three channel differences.
  always_comb begin
    for (int i = 0; i < PAL_SIZE; i++) begin
      rgb_t       e;
      logic [7:0] dr;
      logic [7:0] dg;
      logic [7:0] db;
      e  = pal_entry(IDX_W'(i));
      dr = abs_diff(color.r, e.r);
      dg = abs_diff(color.g, e.g);
      db = abs_diff(color.b, e.b);
      cands[i].score = {2'b00, dr} + {2'b00, dg} + {2'b00, db};
      cands[i].idx   = IDX_W'(i);
    end
  end

endmodule

// File: sv/nhcm_min.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Minimum search tree
// Four-level comparison tree over the sixteen lanes; the lower palette
// position wins on equal distance.
// ----------------------------------------------------------------------------
module nhcm_min
  import nhcm_pkg::*;
(
  input  cand_t [PAL_SIZE-1:0] cands,
  output logic  [IDX_W-1:0]    best_idx
);

  cand_t lvl1 [8];
  cand_t lvl2 [4];
  cand_t lvl3 [2];
  cand_t best;

  // Pairwise reduction, always with the lower positions on the left.
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      lvl1[i] = pick_best(cands[2*i], cands[2*i+1]);
    end
    for (int i = 0; i < 4; i++) begin
      lvl2[i] = pick_best(lvl1[2*i], lvl1[2*i+1]);
    end
    for (int i = 0; i < 2; i++) begin
      lvl3[i] = pick_best(lvl2[2*i], lvl2[2*i+1]);
    end
    best = pick_best(lvl3[0], lvl3[1]);
  end

  assign best_idx = best.idx;

endmodule

// File: sv/nearest_highlight_color_match_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Nearest highlight colour match unit
// Returns the 1-based index of the highlight palette entry closest to an RGB
// colour by sum of absolute channel differences.
// ----------------------------------------------------------------------------
// The unit takes one colour item per clock cycle unless the output stalls and
// returns one index item per colour, in order. Each item passes through the
// input register and then the result register, with the sixteen distance lanes
// and the four-level minimum tree between them. The result register decouples
// the two sides, so a new colour is taken while a finished index waits; when
// the output stalls with both registers full, the colour channel stalls too.
// The unit holds no state beyond these two registers and needs no set-up.
module nearest_highlight_color_match_unit
  import nhcm_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  nhcm_color_if.sink          color_in,
  nhcm_index_if.source        index_out
);

  logic               s1_valid;
  rgb_t               s1_color;
  logic               s1_advance;
  logic               out_valid;
  logic [INDEX_W-1:0] out_index;

  cand_t [PAL_SIZE-1:0] cands;
  logic  [IDX_W-1:0]    best_idx;

  // Handshake: the result register frees when empty or being taken.
  assign s1_advance     = !out_valid || index_out.ready;
  assign color_in.ready = !s1_valid || s1_advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (color_in.ready) begin
      s1_valid <= color_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (color_in.ready && color_in.valid) begin
      s1_color <= rgb_t'(color_in.color_rgb);
    end
  end

  // Distance lanes and minimum search.
  nhcm_dist u_dist (
    .color (s1_color),
    .cands (cands)
  );

  nhcm_min u_min (
    .cands    (cands),
    .best_idx (best_idx)
  );

  // Result register: the index is reported 1-based.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance && s1_valid) begin
      out_index <= {1'b0, best_idx} + INDEX_W'(1);
    end
  end

  assign index_out.valid           = out_valid;
  assign index_out.highlight_index = out_index;

  // A valid result always names a palette entry.
  a_index_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_index != '0) && (out_index <= INDEX_W'(PAL_SIZE)))
    else $error("highlight index out of range");

  // An accepted colour occupies the input register in the next cycle.
  a_accept_fills: assert property (@(posedge clk) disable iff (rst)
    (color_in.valid && color_in.ready) |=> s1_valid)
    else $error("accepted item lost from input register");

  // A held item in the input register keeps its colour.
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_advance) |=> (s1_valid && $stable(s1_color)))
    else $error("stalled item changed in input register");

  // An empty input register never refuses a colour.
  a_ready_empty: assert property (@(posedge clk) disable iff (rst)
    !s1_valid |-> color_in.ready)
    else $error("input stalled with empty input register");

endmodule
